[rtl/hse_pkg.sv]
`default_nettype none

package hse_pkg;

   // per-stage control that travels with the data
   typedef struct packed {
      logic valid;
      logic pos;
   } ctl_type;

   // digit-by-digit square root working state
   typedef struct packed {
      logic [63:0] rad;
      logic [35:0] rem;
      logic [31:0] root;
   } sqrt_state_type;

   typedef enum logic [2:0] {
      REG_TANGENT_X,
      REG_TANGENT_Y,
      REG_TANGENT_Z,
      REG_OFFSET_COS,
      REG_OFFSET_SIN,
      REG_LOBE_EXPONENT
   } reg_index_type;

   localparam int SQ_STAGES   = 16;
   localparam int SINE_LAT    = SQ_STAGES + 1;
   localparam int LOG_FRAC    = 24;
   localparam int LOG_LAT     = LOG_FRAC + 3;
   localparam int EXP_FRAC    = 16;
   localparam int EXP_LAT     = EXP_FRAC + 1;

   localparam logic [31:0] INV_PI2_Q32 = 32'd435171170;
   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

   // one root bit: shift in two radicand bits, trial subtract
   function automatic sqrt_state_type sqrt_iter(sqrt_state_type s);
      logic [35:0]    rem_sh;
      logic [35:0]    trial;
      sqrt_state_type r;
      rem_sh = {s.rem[33:0], s.rad[63:62]};
      trial  = {2'b00, s.root, 2'b01};
      r.rad  = {s.rad[61:0], 2'b00};
      if (rem_sh >= trial) begin
         r.rem  = rem_sh - trial;
         r.root = {s.root[30:0], 1'b1};
      end else begin
         r.rem  = rem_sh;
         r.root = {s.root[30:0], 1'b0};
      end
      return r;
   endfunction

   // elaboration only: floor square root of a 64 bit value
   function automatic logic [31:0] isqrt64(logic [63:0] v);
      sqrt_state_type s;
      s.rad  = v;
      s.rem  = '0;
      s.root = '0;
      for (int i = 0; i < 32; i++) begin
         s = sqrt_iter(s);
      end
      return s.root;
   endfunction

   // 2^(2^-k) in Q.30 by repeated floor square roots of 2.0
   function automatic logic [31:0] exp_factor(int k);
      logic [63:0] r;
      r = 64'h8000_0000;
      for (int i = 1; i <= k; i++) begin
         r = {32'b0, isqrt64({r[33:0], 30'b0})};
      end
      return r[31:0];
   endfunction

endpackage

`default_nettype wire

[rtl/hse_sine.sv]
`default_nettype none

module hse_sine import hse_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic signed [31:0] in_cos_i,
   input  wire logic signed [31:0] in_cos_o,
   output logic                    out_valid,
   output logic [31:0]             out_sin_i,
   output logic [31:0]             out_sin_o,
   output logic signed [31:0]      out_cos_i,
   output logic signed [31:0]      out_cos_o
);

   logic [SQ_STAGES:0]  valid_ff;
   logic signed [31:0]  cos_i_ff [0:SQ_STAGES];
   logic signed [31:0]  cos_o_ff [0:SQ_STAGES];
   sqrt_state_type      st_i_ff  [0:SQ_STAGES];
   sqrt_state_type      st_o_ff  [0:SQ_STAGES];
   sqrt_state_type      st_i_in  [0:SQ_STAGES];
   sqrt_state_type      st_o_in  [0:SQ_STAGES];
   logic signed [63:0]  sq_i;
   logic signed [63:0]  sq_o;

   // radicand 1 - c^2 in Q.60
   always_comb begin
      sq_i = 64'(in_cos_i) * 64'(in_cos_i);
      sq_o = 64'(in_cos_o) * 64'(in_cos_o);
      st_i_in[0].rad  = 64'h1000_0000_0000_0000 - 64'(sq_i);
      st_i_in[0].rem  = '0;
      st_i_in[0].root = '0;
      st_o_in[0].rad  = 64'h1000_0000_0000_0000 - 64'(sq_o);
      st_o_in[0].rem  = '0;
      st_o_in[0].root = '0;
   end

   for (genvar g = 0; g < SQ_STAGES; g++) begin : g_root
      always_comb begin
         st_i_in[g+1] = sqrt_iter(sqrt_iter(st_i_ff[g]));
         st_o_in[g+1] = sqrt_iter(sqrt_iter(st_o_ff[g]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[SQ_STAGES-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      cos_i_ff[0] <= in_cos_i;
      cos_o_ff[0] <= in_cos_o;
      for (int i = 0; i <= SQ_STAGES; i++) begin
         st_i_ff[i] <= st_i_in[i];
         st_o_ff[i] <= st_o_in[i];
      end
      for (int i = 1; i <= SQ_STAGES; i++) begin
         cos_i_ff[i] <= cos_i_ff[i-1];
         cos_o_ff[i] <= cos_o_ff[i-1];
      end
   end

   assign out_valid = valid_ff[SQ_STAGES];
   assign out_sin_i = st_i_ff[SQ_STAGES].root;
   assign out_sin_o = st_o_ff[SQ_STAGES].root;
   assign out_cos_i = cos_i_ff[SQ_STAGES];
   assign out_cos_o = cos_o_ff[SQ_STAGES];

endmodule

`default_nettype wire

[rtl/hse_log2.sv]
`default_nettype none

module hse_log2 import hse_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctl_type            in_ctl,
   input  wire logic [30:0]        in_x,
   output ctl_type                 out_ctl,
   output logic signed [29:0]      out_log
);

   localparam int NCTL = LOG_FRAC + 3;

   ctl_type             ctl_ff [0:NCTL-1];
   logic [30:0]         n1_x_ff;
   logic [4:0]          n1_lz_ff;
   logic [30:0]         n1_x_in;
   logic [4:0]          n1_lz_in;
   logic [30:0]         n2_x_in;
   logic [4:0]          n2_lz_in;
   logic [30:0]         m_ff    [0:LOG_FRAC];
   logic [23:0]         frac_ff [0:LOG_FRAC];
   logic [4:0]          lz_ff   [0:LOG_FRAC];
   logic [30:0]         m_in    [1:LOG_FRAC];
   logic [23:0]         frac_in [1:LOG_FRAC];
   logic signed [29:0]  log_ff;

   // normalize so the leading one sits at bit 30: coarse shifts
   always_comb begin
      logic [30:0] x;
      logic [4:0]  lz;
      x  = in_x;
      lz = 5'd0;
      if (x[30:15] == 16'd0) begin
         x  = {x[14:0], 16'b0};
         lz = lz + 5'd16;
      end
      if (x[30:23] == 8'd0) begin
         x  = {x[22:0], 8'b0};
         lz = lz + 5'd8;
      end
      n1_x_in  = x;
      n1_lz_in = lz;
   end

   // fine shifts
   always_comb begin
      logic [30:0] x;
      logic [4:0]  lz;
      x  = n1_x_ff;
      lz = n1_lz_ff;
      if (x[30:27] == 4'd0) begin
         x  = {x[26:0], 4'b0};
         lz = lz + 5'd4;
      end
      if (x[30:29] == 2'd0) begin
         x  = {x[28:0], 2'b0};
         lz = lz + 5'd2;
      end
      if (!x[30]) begin
         x  = {x[29:0], 1'b0};
         lz = lz + 5'd1;
      end
      n2_x_in  = x;
      n2_lz_in = lz;
   end

   // one fraction bit per squaring
   for (genvar g = 1; g <= LOG_FRAC; g++) begin : g_sq
      always_comb begin
         logic [61:0] sq;
         sq = 62'(m_ff[g-1]) * 62'(m_ff[g-1]);
         if (sq[61]) begin
            m_in[g]    = sq[61:31];
            frac_in[g] = {frac_ff[g-1][22:0], 1'b1};
         end else begin
            m_in[g]    = sq[60:30];
            frac_in[g] = {frac_ff[g-1][22:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCTL; i++) begin
            ctl_ff[i] <= '0;
         end
      end else begin
         ctl_ff[0] <= in_ctl;
         for (int i = 1; i < NCTL; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      n1_x_ff    <= n1_x_in;
      n1_lz_ff   <= n1_lz_in;
      m_ff[0]    <= n2_x_in;
      lz_ff[0]   <= n2_lz_in;
      frac_ff[0] <= '0;
      for (int i = 1; i <= LOG_FRAC; i++) begin
         m_ff[i]    <= m_in[i];
         frac_ff[i] <= frac_in[i];
         lz_ff[i]   <= lz_ff[i-1];
      end
      log_ff <= $signed({6'b0, frac_ff[LOG_FRAC]}) - $signed({1'b0, lz_ff[LOG_FRAC], 24'b0});
   end

   assign out_ctl = ctl_ff[NCTL-1];
   assign out_log = log_ff;

endmodule

`default_nettype wire

[rtl/hse_exp2.sv]
`default_nettype none

module hse_exp2 import hse_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctl_type            in_ctl,
   input  wire logic signed [46:0] in_t,
   output ctl_type                 out_ctl,
   output logic [31:0]             out_y
);

   ctl_type      ctl_ff   [0:EXP_FRAC];
   logic [31:0]  acc_ff   [0:EXP_FRAC-1];
   logic [15:0]  fb_ff    [0:EXP_FRAC-1];
   logic [15:0]  sh_ff    [0:EXP_FRAC-1];
   logic [31:0]  acc_prev [0:EXP_FRAC-1];
   logic [15:0]  fb_prev  [0:EXP_FRAC-1];
   logic [15:0]  sh_prev  [0:EXP_FRAC-1];
   logic [31:0]  acc_in   [0:EXP_FRAC-1];
   logic [31:0]  y_ff;

   // integer part becomes a right shift, top fraction bits pick factors
   assign acc_prev[0] = {1'b0, ONE_Q30};
   assign fb_prev[0]  = in_t[31:16];
   assign sh_prev[0]  = -16'($signed(in_t[46:32]));

   for (genvar g = 0; g < EXP_FRAC; g++) begin : g_fact
      localparam logic [31:0] FACT = exp_factor(g + 1);
      if (g > 0) begin : g_link
         assign acc_prev[g] = acc_ff[g-1];
         assign fb_prev[g]  = fb_ff[g-1];
         assign sh_prev[g]  = sh_ff[g-1];
      end
      always_comb begin
         logic [63:0] p;
         p = 64'(acc_prev[g]) * 64'(FACT);
         if (fb_prev[g][EXP_FRAC-1-g]) begin
            acc_in[g] = p[61:30];
         end else begin
            acc_in[g] = acc_prev[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= EXP_FRAC; i++) begin
            ctl_ff[i] <= '0;
         end
      end else begin
         ctl_ff[0] <= in_ctl;
         for (int i = 1; i <= EXP_FRAC; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < EXP_FRAC; i++) begin
         acc_ff[i] <= acc_in[i];
         fb_ff[i]  <= fb_prev[i];
         sh_ff[i]  <= sh_prev[i];
      end
      if (sh_ff[EXP_FRAC-1] > 16'd31) begin
         y_ff <= '0;
      end else begin
         y_ff <= acc_ff[EXP_FRAC-1] >> sh_ff[EXP_FRAC-1][4:0];
      end
   end

   assign out_ctl = ctl_ff[EXP_FRAC];
   assign out_y   = y_ff;

endmodule

`default_nettype wire

[rtl/hair_specular_eval.sv]
`default_nettype none

// channel   direction  ports                                   transfer when
// request   in         start, busy, req_in_dir_*, req_out_dir_* start high, busy low
// result    out        rsp_valid, rsp_reflectance, rsp_density  rsp_valid high (one cycle)
// config    in/out     psel, penable, pwrite, paddr, pwdata,    psel, penable, pwrite,
//                      prdata, pready                           pready high
//
// one request per cycle while busy is low; each result follows its transfer through
// the 16 stage square root, 24 squaring log2 and 16 factor exp2 chains plus the
// dot, mix and scale stages around them
// busy is high only during reset; synchronous reset clears all valid bits
// results cannot be held off, so the pipeline never stalls

module hair_specular_eval import hse_pkg::*; #(
   parameter int VEC_FRAC_BITS = 15
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_in_dir_x,
   input  wire logic [15:0] req_in_dir_y,
   input  wire logic [15:0] req_in_dir_z,
   input  wire logic [15:0] req_out_dir_x,
   input  wire logic [15:0] req_out_dir_y,
   input  wire logic [15:0] req_out_dir_z,
   output logic             rsp_valid,
   output logic [15:0]      rsp_reflectance,
   output logic [15:0]      rsp_density,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int F2  = 2 * VEC_FRAC_BITS;
   localparam int LAT = 2 + SINE_LAT + 3 + LOG_LAT + 1 + EXP_LAT + 2;

   // configuration registers
   logic [15:0] tangent_x_ff, tangent_y_ff, tangent_z_ff;
   logic [15:0] offset_cos_ff, offset_sin_ff, lobe_exponent_ff;
   logic        cfg_write;
   logic        req_take;

   // stage a: tangent products
   logic               a_valid_ff;
   logic signed [31:0] a_pi_ff [0:2];
   logic signed [31:0] a_po_ff [0:2];
   // stage b: cosines
   logic               b_valid_ff;
   logic signed [31:0] b_ci_ff, b_co_ff;
   logic signed [31:0] b_ci_in, b_co_in;
   logic signed [33:0] dot_i, dot_o;
   logic signed [47:0] sc_i, sc_o;
   // sine pipeline
   logic               sn_valid;
   logic [31:0]        sn_si, sn_so;
   logic signed [31:0] sn_ci, sn_co;
   // stage c: cross products
   logic               c_valid_ff;
   logic signed [31:0] c_a_ff, c_b_ff, c_c_ff, c_d_ff;
   logic signed [63:0] c_pa, c_pb, c_pc, c_pd;
   // stage d: offset products
   logic               d_valid_ff;
   logic signed [48:0] d_m1_ff, d_m2_ff, d_m3_ff;
   logic signed [32:0] d_bc;
   // stage e: lobe cosine
   ctl_type            e_ctl_ff;
   logic [30:0]        e_x_ff;
   logic signed [50:0] e_sum;
   logic signed [50:0] e_cd;
   logic [30:0]        e_x_in;
   // log2, exponent product, exp2
   ctl_type            lg_ctl;
   logic signed [29:0] lg_log;
   ctl_type            f_ctl_ff;
   logic signed [46:0] f_t_ff;
   ctl_type            ex_ctl;
   logic [31:0]        ex_y;
   // stage g, h: 1/pi^2 scale and saturate
   ctl_type            g_ctl_ff;
   logic [63:0]        g_prod_ff;
   logic               h_valid_ff;
   logic [15:0]        h_refl_ff;
   logic [15:0]        h_refl_in;

   assign busy     = reset;
   assign req_take = start && !busy;
   assign pready   = 1'b1;

   // ---------------- configuration port ----------------
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tangent_x_ff     <= 16'd0;
         tangent_y_ff     <= 16'd0;
         tangent_z_ff     <= 16'd32767;
         offset_cos_ff    <= 16'd32767;
         offset_sin_ff    <= 16'd0;
         lobe_exponent_ff <= 16'd256;
      end else if (cfg_write) begin
         unique case (reg_index_type'(paddr[4:2]))
            REG_TANGENT_X:     tangent_x_ff     <= pwdata[15:0];
            REG_TANGENT_Y:     tangent_y_ff     <= pwdata[15:0];
            REG_TANGENT_Z:     tangent_z_ff     <= pwdata[15:0];
            REG_OFFSET_COS:    offset_cos_ff    <= pwdata[15:0];
            REG_OFFSET_SIN:    offset_sin_ff    <= pwdata[15:0];
            REG_LOBE_EXPONENT: lobe_exponent_ff <= pwdata[15:0];
            default: ;  // unmapped addresses ignore the transfer
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(paddr[4:2]))
         REG_TANGENT_X:     prdata = {16'b0, tangent_x_ff};
         REG_TANGENT_Y:     prdata = {16'b0, tangent_y_ff};
         REG_TANGENT_Z:     prdata = {16'b0, tangent_z_ff};
         REG_OFFSET_COS:    prdata = {16'b0, offset_cos_ff};
         REG_OFFSET_SIN:    prdata = {16'b0, offset_sin_ff};
         REG_LOBE_EXPONENT: prdata = {16'b0, lobe_exponent_ff};
         default:           prdata = 32'b0;
      endcase
   end

   // ---------------- stage a: T.in and T.out products ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      a_pi_ff[0] <= $signed(tangent_x_ff) * $signed(req_in_dir_x);
      a_pi_ff[1] <= $signed(tangent_y_ff) * $signed(req_in_dir_y);
      a_pi_ff[2] <= $signed(tangent_z_ff) * $signed(req_in_dir_z);
      a_po_ff[0] <= $signed(tangent_x_ff) * $signed(req_out_dir_x);
      a_po_ff[1] <= $signed(tangent_y_ff) * $signed(req_out_dir_y);
      a_po_ff[2] <= $signed(tangent_z_ff) * $signed(req_out_dir_z);
   end

   // ---------------- stage b: sum, rescale to Q.30, clamp to [-1,1] ----------------
   assign dot_i = 34'(a_pi_ff[0]) + 34'(a_pi_ff[1]) + 34'(a_pi_ff[2]);
   assign dot_o = 34'(a_po_ff[0]) + 34'(a_po_ff[1]) + 34'(a_po_ff[2]);

   if (F2 > 30) begin : g_scale_down
      assign sc_i = 48'(dot_i) >>> (F2 - 30);
      assign sc_o = 48'(dot_o) >>> (F2 - 30);
   end else begin : g_scale_up
      assign sc_i = 48'(dot_i) <<< (30 - F2);
      assign sc_o = 48'(dot_o) <<< (30 - F2);
   end

   function automatic logic signed [31:0] clamp_q30(logic signed [47:0] v);
      if (v > 48'sh0000_4000_0000) begin
         return 32'sh4000_0000;
      end else if (v < -48'sh0000_4000_0000) begin
         return -32'sh4000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

   assign b_ci_in = clamp_q30(sc_i);
   assign b_co_in = clamp_q30(sc_o);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_ci_ff <= b_ci_in;
      b_co_ff <= b_co_in;
   end

   // ---------------- sines ----------------
   hse_sine u_sine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid_ff),
      .in_cos_i  (b_ci_ff),
      .in_cos_o  (b_co_ff),
      .out_valid (sn_valid),
      .out_sin_i (sn_si),
      .out_sin_o (sn_so),
      .out_cos_i (sn_ci),
      .out_cos_o (sn_co)
   );

   // ---------------- stage c: Q.30 cross products, floor ----------------
   assign c_pa = 64'($signed(sn_si)) * 64'($signed(sn_so));
   assign c_pb = 64'($signed(sn_si)) * 64'(sn_co);
   assign c_pc = 64'(sn_ci) * 64'($signed(sn_so));
   assign c_pd = 64'(sn_ci) * 64'(sn_co);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= sn_valid;
      end
   end

   always_ff @(posedge clock) begin
      c_a_ff <= 32'(c_pa >>> 30);
      c_b_ff <= 32'(c_pb >>> 30);
      c_c_ff <= 32'(c_pc >>> 30);
      c_d_ff <= 32'(c_pd >>> 30);
   end

   // ---------------- stage d: weight by offset cosine and sine ----------------
   assign d_bc = 33'(c_b_ff) + 33'(c_c_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_m1_ff <= 49'(c_a_ff) * 49'($signed(offset_cos_ff));
      d_m2_ff <= 49'(d_bc) * 49'($signed(offset_sin_ff));
      d_m3_ff <= 49'(c_d_ff) * 49'($signed(offset_cos_ff));
   end

   // ---------------- stage e: lobe cosine, sign test, clamp at one ----------------
   assign e_sum = 51'(d_m1_ff) + 51'(d_m2_ff) - 51'(d_m3_ff);
   assign e_cd  = e_sum >>> VEC_FRAC_BITS;

   always_comb begin
      if (e_cd <= 51'sd0) begin
         e_x_in = 31'd1;  // keeps log2 defined, result is masked later
      end else if (e_cd > 51'(ONE_Q30)) begin
         e_x_in = ONE_Q30;
      end else begin
         e_x_in = e_cd[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ctl_ff <= '0;
      end else begin
         e_ctl_ff.valid <= d_valid_ff;
         e_ctl_ff.pos   <= e_cd > 51'sd0;
      end
   end

   always_ff @(posedge clock) begin
      e_x_ff <= e_x_in;
   end

   // ---------------- log2 ----------------
   hse_log2 u_log2 (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (e_ctl_ff),
      .in_x    (e_x_ff),
      .out_ctl (lg_ctl),
      .out_log (lg_log)
   );

   // ---------------- stage f: times the Q8.8 exponent ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         f_ctl_ff <= '0;
      end else begin
         f_ctl_ff <= lg_ctl;
      end
   end

   always_ff @(posedge clock) begin
      f_t_ff <= 47'(lg_log) * 47'($signed({1'b0, lobe_exponent_ff}));
   end

   // ---------------- exp2 ----------------
   hse_exp2 u_exp2 (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (f_ctl_ff),
      .in_t    (f_t_ff),
      .out_ctl (ex_ctl),
      .out_y   (ex_y)
   );

   // ---------------- stage g: scale by 1/pi^2 ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         g_ctl_ff <= '0;
      end else begin
         g_ctl_ff <= ex_ctl;
      end
   end

   always_ff @(posedge clock) begin
      g_prod_ff <= 64'(ex_y) * 64'(INV_PI2_Q32);
   end

   // ---------------- stage h: saturate, zero for non-positive lobe cosine ----------------
   always_comb begin
      if (!g_ctl_ff.pos) begin
         h_refl_in = 16'd0;
      end else if (g_prod_ff[63:62] != 2'b00) begin
         h_refl_in = 16'hFFFF;
      end else begin
         h_refl_in = g_prod_ff[61:46];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else begin
         h_valid_ff <= g_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      h_refl_ff <= h_refl_in;
   end

   assign rsp_valid       = h_valid_ff;
   assign rsp_reflectance = h_refl_ff;
   assign rsp_density     = 16'd0;

`ifndef SYNTHESIS
   // every result comes from an earlier request transfer
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_take, LAT))
      else $error("result without matching request");

   // the power never exceeds one, so the lobe stays at or below 1/pi^2
   a_refl_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reflectance <= 16'd6640))
      else $error("reflectance above 1/pi^2");

   // a cleared sign flag must give a zero result one stage later
   a_neg_zero: assert property (@(posedge clock) disable iff (reset)
      (g_ctl_ff.valid && !g_ctl_ff.pos) |=> (rsp_valid && rsp_reflectance == 16'd0))
      else $error("non-positive lobe cosine gave nonzero result");
`endif

endmodule

`default_nettype wire
